FILE: rtl/scfr_pkg.sv
package scfr_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 5;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hFD;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_DATA = 3'd3,
		PH_SUM  = 3'd4
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD   = 1'b0,
		KIND_FRAME_END = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             item_kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [IDX_W-1:0]  payload_index;
		logic [BYTE_W-1:0] frame_type;
		logic [IDX_W-1:0]  frame_length;
		logic              checksum_ok;
		logic [BYTE_W-1:0] received_sum;
		logic [BYTE_W-1:0] computed_sum;
	} result_t;

endpackage

FILE: rtl/sum_checksum_frame_receiver.sv
// Byte-serial frame receiver: HEADER, LEN, TYPE, PAYLOAD[LEN-1], CHECKSUM.
// Input channel: in_valid / in_stall with rx_byte, one received byte per beat.
// Output channel: out_valid / out_stall with the result fields. Each payload
// byte goes out as a payload beat (item_kind 0) with its index; the checksum
// byte gives one frame-end beat (item_kind 1) with type, length, both sums
// and checksum_ok. Header, length and type bytes give no output beat.
// header_we / header_wdata write the header byte to hunt for (reset 0xFD);
// write it only while the block is idle.
// Path: a byte taken on the input lands in the input register, is parsed
// there, and its result is loaded into the output register, from which it
// is offered on the output channel.
// Throughput is one byte per cycle while no stalled result blocks the
// input, set by the state update and running 8-bit sum made per byte.
// When out_stall holds a waiting result, the input register cannot hand on
// its byte, even one that gives no result; in_stall rises while the input
// register is full and the output register holds a stalled beat.
// Reset clears both registers and sends the parser back to hunting.
module sum_checksum_frame_receiver #(
	parameter int FRAME_BUFFER_BYTES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        header_we,
	input  logic [scfr_pkg::BYTE_W-1:0] header_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [scfr_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        item_kind,
	output logic [scfr_pkg::BYTE_W-1:0] payload_byte,
	output logic [scfr_pkg::IDX_W-1:0]  payload_index,
	output logic [scfr_pkg::BYTE_W-1:0] frame_type,
	output logic [scfr_pkg::IDX_W-1:0]  frame_length,
	output logic                        checksum_ok,
	output logic [scfr_pkg::BYTE_W-1:0] received_sum,
	output logic [scfr_pkg::BYTE_W-1:0] computed_sum
);

	logic [scfr_pkg::BYTE_W-1:0] header_q;
	logic valid_s1;
	logic [scfr_pkg::BYTE_W-1:0] rx_byte_s1;
	logic out_ready;
	logic advance;
	logic in_accept;
	logic res_valid;
	scfr_pkg::result_t res;
	scfr_pkg::result_t out_data;

	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= scfr_pkg::HEADER_RESET;
		end else if (header_we) begin
			header_q <= header_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	scfr_parser #(
		.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte    (rx_byte_s1),
		.header_byte(header_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	scfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_valid(res_valid),
		.load_data (res),
		.out_stall (out_stall),
		.ready     (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign item_kind     = out_data.item_kind;
	assign payload_byte  = out_data.payload_byte;
	assign payload_index = out_data.payload_index;
	assign frame_type    = out_data.frame_type;
	assign frame_length  = out_data.frame_length;
	assign checksum_ok   = out_data.checksum_ok;
	assign received_sum  = out_data.received_sum;
	assign computed_sum  = out_data.computed_sum;

`ifndef SYNTHESIS
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked byte");

	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(rx_byte_s1)))
		else $error("blocked byte lost from input register");
`endif

endmodule

FILE: rtl/scfr_parser.sv
module scfr_parser #(
	parameter int FRAME_BUFFER_BYTES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [scfr_pkg::BYTE_W-1:0] rx_byte,
	input  logic [scfr_pkg::BYTE_W-1:0] header_byte,
	output logic                        res_valid,
	output scfr_pkg::result_t           res
);

	localparam int LEN_W = $clog2(FRAME_BUFFER_BYTES - 2);
	localparam logic [scfr_pkg::BYTE_W-1:0] MAX_LEN =
		scfr_pkg::BYTE_W'(FRAME_BUFFER_BYTES - 3);

	scfr_pkg::phase_t phase_q, phase_d;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [scfr_pkg::BYTE_W-1:0] type_q;
	logic [scfr_pkg::BYTE_W-1:0] sum_q;
	logic [scfr_pkg::BYTE_W-1:0] sum_add;
	logic len_ok;
	logic data_done;
	logic [LEN_W+scfr_pkg::IDX_W-1:0] idx_ext;
	logic [LEN_W+scfr_pkg::IDX_W-1:0] len_ext;

	assign len_ok    = (rx_byte != '0) && (rx_byte <= MAX_LEN);
	assign sum_add   = sum_q + rx_byte;
	// last payload beat once count after this one reaches length minus one
	assign data_done = ({1'b0, cnt_q} + (LEN_W+1)'(2)) >= {1'b0, len_q};
	assign idx_ext   = {{scfr_pkg::IDX_W{1'b0}}, cnt_q};
	assign len_ext   = {{scfr_pkg::IDX_W{1'b0}}, len_q};

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			scfr_pkg::PH_HUNT: begin
				if (rx_byte == header_byte) phase_d = scfr_pkg::PH_LEN;
			end
			scfr_pkg::PH_LEN: begin
				phase_d = len_ok ? scfr_pkg::PH_TYPE : scfr_pkg::PH_HUNT;
			end
			scfr_pkg::PH_TYPE: begin
				phase_d = (len_q == LEN_W'(1)) ? scfr_pkg::PH_SUM : scfr_pkg::PH_DATA;
			end
			scfr_pkg::PH_DATA: begin
				phase_d = data_done ? scfr_pkg::PH_SUM : scfr_pkg::PH_DATA;
			end
			scfr_pkg::PH_SUM: begin
				phase_d = scfr_pkg::PH_HUNT;
			end
			default: begin
				phase_d = scfr_pkg::PH_HUNT;
			end
		endcase
	end

	always_comb begin
		res_valid         = 1'b0;
		res.item_kind     = scfr_pkg::KIND_PAYLOAD;
		res.payload_byte  = '0;
		res.payload_index = '0;
		res.frame_type    = type_q;
		res.frame_length  = len_ext[scfr_pkg::IDX_W-1:0];
		res.checksum_ok   = 1'b0;
		res.received_sum  = '0;
		res.computed_sum  = '0;
		case (phase_q)
			scfr_pkg::PH_DATA: begin
				res_valid         = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = idx_ext[scfr_pkg::IDX_W-1:0];
			end
			scfr_pkg::PH_SUM: begin
				res_valid        = 1'b1;
				res.item_kind    = scfr_pkg::KIND_FRAME_END;
				res.checksum_ok  = (rx_byte == sum_q);
				res.received_sum = rx_byte;
				res.computed_sum = sum_q;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scfr_pkg::PH_HUNT;
			len_q   <= '0;
			cnt_q   <= '0;
			type_q  <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				scfr_pkg::PH_LEN: begin
					if (len_ok) begin
						len_q <= rx_byte[LEN_W-1:0];
						cnt_q <= '0;
						sum_q <= rx_byte;
					end
				end
				scfr_pkg::PH_TYPE: begin
					type_q <= rx_byte;
					sum_q  <= sum_add;
				end
				scfr_pkg::PH_DATA: begin
					sum_q <= sum_add;
					cnt_q <= cnt_q + LEN_W'(1);
				end
				default: begin
					sum_q <= sum_q;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_hunt_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == scfr_pkg::PH_HUNT || phase_q == scfr_pkg::PH_LEN ||
		 phase_q == scfr_pkg::PH_TYPE) |-> !res_valid)
		else $error("result raised outside payload or checksum phase");

	a_sum_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == scfr_pkg::PH_SUM) |=> phase_q == scfr_pkg::PH_HUNT)
		else $error("checksum beat did not return to hunting");

	a_data_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == scfr_pkg::PH_DATA) |->
		({1'b0, cnt_q} + (LEN_W+1)'(2)) <= {1'b0, len_q})
		else $error("payload count ran past frame length");
`endif

endmodule

FILE: rtl/scfr_out_reg.sv
module scfr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              load_valid,
	input  scfr_pkg::result_t load_data,
	input  logic              out_stall,
	output logic              ready,
	output logic              out_valid,
	output scfr_pkg::result_t out_data
);

	logic valid_q;
	scfr_pkg::result_t data_q;

	// slot is free when empty or being taken this cycle
	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load && load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load && load_valid) begin
			data_q <= load_data;
		end
	end

endmodule
